// ===== rtl/epfs_pkg.sv =====
// Shared constants and types of the e-paper frame scanout engine.
`timescale 1ns / 1ps
`default_nettype none

package epfs_pkg;

  localparam int PANEL_WIDTH  = 792;
  localparam int PANEL_HEIGHT = 272;

  // Frame store word: four 2-bit pixels, leftmost pixel in bits 7:6.
  localparam int CODE_W      = 2;
  localparam int WORD_W      = 8;
  localparam int ROW_WORDS   = (PANEL_WIDTH + 3) / 4;
  localparam int STORE_WORDS = ROW_WORDS * PANEL_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  // Config register indexes.
  localparam logic [1:0] REG_BLACK  = 2'd0;
  localparam logic [1:0] REG_WHITE  = 2'd1;
  localparam logic [1:0] REG_YELLOW = 2'd2;
  localparam logic [1:0] REG_RED    = 2'd3;

  // Input commands carried on s_tuser.
  localparam logic [1:0] CMD_DRAW = 2'd0;
  localparam logic [1:0] CMD_FILL = 2'd1;
  localparam logic [1:0] CMD_EMIT = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  // Refresh stream bytes.
  localparam logic [7:0] BYTE_BANK_CMD = 8'hA2;
  localparam logic [7:0] BYTE_BANK_ONE = 8'h01;
  localparam logic [7:0] BYTE_BANK_TWO = 8'h02;
  localparam logic [7:0] BYTE_WRITE    = 8'h10;
  localparam logic [7:0] BYTE_REFRESH  = 8'h12;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;

  typedef enum logic [1:0] {
    OP_DRAW,
    OP_FILL,
    OP_EMIT
  } op_kind_t;

  // Classified work item handed from front to back.
  typedef struct packed {
    op_kind_t            kind;
    logic [ADDR_W-1:0]   addr;
    logic [1:0]          lane;
    logic [CODE_W-1:0]   code;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/epfs_front.sv =====
// Front end: config registers, command decode, color classification, address calc.
`timescale 1ns / 1ps
`default_nettype none

module epfs_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_addr,
  input  wire logic [1:0]           cfg_wdata,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [47:0]          s_tdata,
  input  wire logic [1:0]           s_tuser,
  input  wire logic                 clearing,
  output logic                      q_push,
  output epfs_pkg::op_t             q_op,
  input  wire logic                 q_ready
);

  logic [1:0] black_code;
  logic [1:0] white_code;
  logic [1:0] yellow_code;
  logic [1:0] red_code;

  logic [9:0] pixel_x;
  logic [8:0] pixel_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [1:0] code;
  logic       on_panel;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_code  <= 2'd0;
      white_code  <= 2'd1;
      yellow_code <= 2'd2;
      red_code    <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        epfs_pkg::REG_BLACK:  black_code  <= cfg_wdata;
        epfs_pkg::REG_WHITE:  white_code  <= cfg_wdata;
        epfs_pkg::REG_YELLOW: yellow_code <= cfg_wdata;
        epfs_pkg::REG_RED:    red_code    <= cfg_wdata;
      endcase
    end
  end

  assign pixel_x = s_tdata[9:0];
  assign pixel_y = s_tdata[18:10];
  assign red     = s_tdata[26:19];
  assign green   = s_tdata[34:27];
  assign blue    = s_tdata[42:35];

  always_comb begin
    priority if (red > 8'd128 && green > 8'd128 && blue < 8'd80) begin
      code = yellow_code;
    end else if (red > 8'd128 && green < 8'd80 && blue < 8'd80) begin
      code = red_code;
    end else if (red < 8'd80 && green < 8'd80 && blue < 8'd80) begin
      code = black_code;
    end else begin
      code = white_code;
    end
  end

  assign on_panel = (32'(pixel_x) < epfs_pkg::PANEL_WIDTH) &&
                    (32'(pixel_y) < epfs_pkg::PANEL_HEIGHT);

  assign s_tready = q_ready && !clearing;

  always_comb begin
    q_op.addr = epfs_pkg::ADDR_W'(pixel_y) * epfs_pkg::ADDR_W'(epfs_pkg::ROW_WORDS)
              + epfs_pkg::ADDR_W'(pixel_x[9:2]);
    q_op.lane = pixel_x[1:0];
    q_op.code = code;
    q_op.kind = epfs_pkg::OP_DRAW;
    q_push    = 1'b0;
    // off-panel draws and the unused command are taken and dropped
    unique case (s_tuser)
      epfs_pkg::CMD_DRAW: begin
        q_op.kind = epfs_pkg::OP_DRAW;
        q_push    = s_tvalid && s_tready && on_panel;
      end
      epfs_pkg::CMD_FILL: begin
        q_op.kind = epfs_pkg::OP_FILL;
        q_push    = s_tvalid && s_tready;
      end
      epfs_pkg::CMD_EMIT: begin
        q_op.kind = epfs_pkg::OP_EMIT;
        q_push    = s_tvalid && s_tready;
      end
      epfs_pkg::CMD_NOP: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/epfs_queue.sv =====
// Two-entry queue of classified ops between front and back.
`timescale 1ns / 1ps
`default_nettype none

module epfs_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire epfs_pkg::op_t push_op,
  output logic               push_ready,
  input  wire logic          pop,
  output epfs_pkg::op_t      pop_op,
  output logic               pop_valid
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  epfs_pkg::op_t      slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_op     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/epfs_back.sv =====
// Back end: frame store, clear/fill sweep, refresh stream sequencer, output register.
`timescale 1ns / 1ps
`default_nettype none

module epfs_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire epfs_pkg::op_t q_op,
  output logic               q_pop,
  output logic               clearing,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,
  output logic [0:0]         m_tuser,
  output logic               m_tlast
);

  localparam int BANK_BYTES = epfs_pkg::PANEL_WIDTH / 8;
  localparam int ROW_PAIRS  = epfs_pkg::PANEL_HEIGHT / 2;
  localparam int BC_W  = (BANK_BYTES > 1) ? $clog2(BANK_BYTES) : 1;
  localparam int RP_W  = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
  localparam int ROW_W = $clog2(epfs_pkg::PANEL_HEIGHT);
  localparam int COL_W = $clog2(2 * BANK_BYTES);
  localparam int AW    = epfs_pkg::ADDR_W;

  localparam logic [2:0] PH_BANK_CMD   = 3'd0;
  localparam logic [2:0] PH_BANK_SEL   = 3'd1;
  localparam logic [2:0] PH_BANK_WRITE = 3'd2;
  localparam logic [2:0] PH_PIXELS     = 3'd3;
  localparam logic [2:0] PH_ON_CMD     = 3'd4;
  localparam logic [2:0] PH_ON_ARG     = 3'd5;
  localparam logic [2:0] PH_ON_REFRESH = 3'd6;
  localparam logic [2:0] PH_ON_TAIL    = 3'd7;

  // white code after reset, in all four lanes
  localparam logic [7:0] RESET_WORD = 8'h55;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_FILL  = 4'b0100,
    ST_PIXEL = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [7:0]      mem [epfs_pkg::STORE_WORDS];
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [3:0]      wr_mask;
  logic [7:0]      wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rdata;

  logic [AW-1:0]   sweep, sweep_next;
  logic [7:0]      fill_word, fill_word_next;

  logic [2:0]      phase, phase_next;
  logic            bank, bank_next;
  logic [RP_W-1:0] row_pair, row_pair_next;
  logic            mirror, mirror_next;
  logic [BC_W-1:0] word_col, word_col_next;

  logic            out_valid, out_valid_next;
  logic [7:0]      out_byte, out_byte_next;
  logic            out_data, out_data_next;
  logic            out_end, out_end_next;

  logic [ROW_W-1:0] row_sel;
  logic [COL_W-1:0] col_sel;
  logic             out_free;
  logic             sweep_last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < 4; k++) begin
        if (wr_mask[k]) begin
          mem[wr_addr][2*k +: 2] <= wr_data[2*k +: 2];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign row_sel = mirror ? ROW_W'(epfs_pkg::PANEL_HEIGHT - 1) - ROW_W'(row_pair)
                          : ROW_W'(row_pair);
  assign col_sel = bank ? COL_W'(word_col) : COL_W'(word_col) + COL_W'(BANK_BYTES);
  assign rd_addr = AW'(row_sel) * AW'(epfs_pkg::ROW_WORDS) + AW'(col_sel);

  assign out_free   = !out_valid || m_tready;
  assign sweep_last = sweep == AW'(epfs_pkg::STORE_WORDS - 1);
  assign clearing   = state == ST_CLEAR;

  always_comb begin
    state_next     = state;
    sweep_next     = sweep;
    fill_word_next = fill_word;
    phase_next     = phase;
    bank_next      = bank;
    row_pair_next  = row_pair;
    mirror_next    = mirror;
    word_col_next  = word_col;
    out_valid_next = out_valid && !m_tready;
    out_byte_next  = out_byte;
    out_data_next  = out_data;
    out_end_next   = out_end;
    wr_en          = 1'b0;
    wr_addr        = q_op.addr;
    wr_mask        = 4'b1000 >> q_op.lane;
    wr_data        = {4{q_op.code}};
    rd_en          = 1'b0;
    q_pop          = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        wr_en      = 1'b1;
        wr_addr    = sweep;
        wr_mask    = 4'b1111;
        wr_data    = RESET_WORD;
        sweep_next = sweep + 1'b1;
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_FILL: begin
        wr_en      = 1'b1;
        wr_addr    = sweep;
        wr_mask    = 4'b1111;
        wr_data    = fill_word;
        sweep_next = sweep + 1'b1;
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_PIXEL: begin
        out_valid_next = 1'b1;
        out_byte_next  = rdata;
        out_data_next  = 1'b1;
        out_end_next   = 1'b0;
        state_next     = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_op.kind)
            epfs_pkg::OP_DRAW: begin
              q_pop = 1'b1;
              wr_en = 1'b1;
            end
            epfs_pkg::OP_FILL: begin
              q_pop          = 1'b1;
              fill_word_next = {4{q_op.code}};
              sweep_next     = '0;
              state_next     = ST_FILL;
            end
            epfs_pkg::OP_EMIT: begin
              if (out_free) begin
                q_pop        = 1'b1;
                out_data_next = 1'b0;
                out_end_next  = 1'b0;
                out_byte_next = epfs_pkg::BYTE_ZERO;
                unique case (phase)
                  PH_BANK_CMD: begin
                    out_valid_next = 1'b1;
                    out_byte_next  = epfs_pkg::BYTE_BANK_CMD;
                    phase_next     = PH_BANK_SEL;
                  end
                  PH_BANK_SEL: begin
                    out_valid_next = 1'b1;
                    out_byte_next  = bank ? epfs_pkg::BYTE_BANK_TWO
                                          : epfs_pkg::BYTE_BANK_ONE;
                    out_data_next  = 1'b1;
                    phase_next     = PH_BANK_WRITE;
                  end
                  PH_BANK_WRITE: begin
                    out_valid_next = 1'b1;
                    out_byte_next  = epfs_pkg::BYTE_WRITE;
                    phase_next     = PH_PIXELS;
                  end
                  PH_PIXELS: begin
                    // byte is loaded in ST_PIXEL from the registered store read
                    out_valid_next = 1'b0;
                    rd_en          = 1'b1;
                    state_next     = ST_PIXEL;
                    if (word_col == BC_W'(BANK_BYTES - 1)) begin
                      word_col_next = '0;
                      if (!mirror) begin
                        mirror_next = 1'b1;
                      end else begin
                        mirror_next = 1'b0;
                        if (row_pair == RP_W'(ROW_PAIRS - 1)) begin
                          row_pair_next = '0;
                          bank_next     = !bank;
                          phase_next    = bank ? PH_ON_CMD : PH_BANK_CMD;
                        end else begin
                          row_pair_next = row_pair + 1'b1;
                        end
                      end
                    end else begin
                      word_col_next = word_col + 1'b1;
                    end
                  end
                  PH_ON_CMD: begin
                    out_valid_next = 1'b1;
                    out_byte_next  = epfs_pkg::BYTE_BANK_CMD;
                    phase_next     = PH_ON_ARG;
                  end
                  PH_ON_ARG: begin
                    out_valid_next = 1'b1;
                    out_data_next  = 1'b1;
                    phase_next     = PH_ON_REFRESH;
                  end
                  PH_ON_REFRESH: begin
                    out_valid_next = 1'b1;
                    out_byte_next  = epfs_pkg::BYTE_REFRESH;
                    phase_next     = PH_ON_TAIL;
                  end
                  PH_ON_TAIL: begin
                    out_valid_next = 1'b1;
                    out_data_next  = 1'b1;
                    out_end_next   = 1'b1;
                    phase_next     = PH_BANK_CMD;
                    bank_next      = 1'b0;
                  end
                endcase
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      phase     <= PH_BANK_CMD;
      bank      <= 1'b0;
      row_pair  <= '0;
      mirror    <= 1'b0;
      word_col  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sweep     <= sweep_next;
      phase     <= phase_next;
      bank      <= bank_next;
      row_pair  <= row_pair_next;
      mirror    <= mirror_next;
      word_col  <= word_col_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fill_word <= fill_word_next;
    out_byte  <= out_byte_next;
    out_data  <= out_data_next;
    out_end   <= out_end_next;
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_byte;
  assign m_tuser[0] = out_data;
  assign m_tlast    = out_end;

endmodule

`default_nettype wire

// ===== rtl/epaper_frame_scanout.sv =====
// Top level of the four-color e-paper frame scanout engine.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  tdata: pixel_x, pixel_y, red, green, blue; tuser: command
//  m_*       out  m_tvalid / m_tready  tdata: spi_byte; tuser: is_data; tlast: frame_end
//  cfg_*     in   cfg_we               cfg_addr: register index; cfg_wdata: code
//
// The back end retires a draw, a header byte or a turn-on byte straight from idle, and
// a pixel byte via ST_PIXEL (registered frame store read of one 4-pixel word).
// A fill sweeps the store one word a cycle, ROW_WORDS * PANEL_HEIGHT = 53856 words.
// After reset the same sweep writes white to every word, with s_tready low.
// A two-entry op queue lets the input side run ahead while the back end
// fills or waits on m_tready; an emit is taken only when the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module epaper_frame_scanout (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [9:0] pixel_x, [18:10] pixel_y, [26:19] red, [34:27] green, [42:35] blue, rest zero
  input  wire logic [47:0] s_tdata,
  // [1:0] command
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] spi_byte
  output logic [7:0]       m_tdata,
  // [0] is_data
  output logic [0:0]       m_tuser,
  output logic             m_tlast
);

  logic          clearing;
  logic          q_push;
  logic          q_ready;
  logic          q_pop;
  logic          q_valid;
  epfs_pkg::op_t push_op;
  epfs_pkg::op_t pop_op;

  epfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .clearing  (clearing),
    .q_push    (q_push),
    .q_op      (push_op),
    .q_ready   (q_ready)
  );

  epfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (push_op),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_op     (pop_op),
    .pop_valid  (q_valid)
  );

  epfs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_op     (pop_op),
    .q_pop    (q_pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // the reset sweep starts right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> clearing)
    else $error("store clearing pass did not start after reset");

  a_no_input_while_clearing: assert property (@(posedge clk) clearing |-> !s_tready)
    else $error("input accepted during store clearing pass");

  a_no_output_while_clearing: assert property (@(posedge clk) clearing |-> !m_tvalid)
    else $error("output beat during store clearing pass");

  a_frame_end_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0] && (m_tdata == 8'h00))
    else $error("frame end marked on a beat other than the last turn-on data byte");
`endif

endmodule

`default_nettype wire
